### rtl/gsb_pkg.sv
package gsb_pkg;

  // field widths
  localparam int COORD_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int CENTER_W = 20;
  localparam int SIZE_W   = 16;
  localparam int OPAC_W   = 9;
  localparam int COLOR_W  = 24;
  localparam int ASPECT_W = 12;
  localparam int CHUSE_W  = 2;
  localparam int FRAC_W   = 8;

  // frame limits
  localparam int DIM_W      = 17;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // datapath widths
  localparam int ROOT_W = SIZE_W;          // root of a squared distance
  localparam int RAD_W  = 2 * ROOT_W;      // squared distance
  localparam int WGT_W  = 17;              // Q1.16 weight, up to 1.0
  localparam int QUO_W  = WGT_W;           // quotient bits
  localparam int NUM_W  = 32;              // dividend width
  localparam int PROD_W = OPAC_W + SIZE_W; // opacity times falloff

  // register map
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE    = 3'd0,
    REG_CENTER_X      = 3'd1,
    REG_CENTER_Y      = 3'd2,
    REG_GRAIN_SIZE    = 3'd3,
    REG_OPACITY       = 3'd4,
    REG_GRAIN_COLOR   = 3'd5,
    REG_ASPECT        = 3'd6,
    REG_CHANNELS_USED = 3'd7
  } reg_idx_t;

  localparam logic SHAPE_CIRCLE = 1'b0;
  localparam logic SHAPE_RECT   = 1'b1;

  localparam logic [SIZE_W-1:0]   RST_GRAIN_SIZE    = 16'd256;
  localparam logic [OPAC_W-1:0]   RST_OPACITY       = 9'd0;
  localparam logic [COLOR_W-1:0]  RST_GRAIN_COLOR   = 24'hFFFFFF;
  localparam logic [ASPECT_W-1:0] RST_ASPECT        = 12'd256;
  localparam logic [CHUSE_W-1:0]  RST_CHANNELS_USED = 2'd3;
  localparam logic [OPAC_W-1:0]   OPAC_FULL         = 9'd256;

  typedef struct packed {
    logic                shape_mode;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [SIZE_W-1:0]   grain_size;
    logic [OPAC_W-1:0]   opacity;
    logic [COLOR_W-1:0]  grain_color;
    logic [ASPECT_W-1:0] aspect;
    logic [CHUSE_W-1:0]  channels_used;
  } cfg_t;

  // pixel data riding along with the weight computation
  typedef struct packed {
    logic              hit;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } side_t;

  function automatic logic [OPAC_W-1:0] sat_opacity(input logic [OPAC_W-1:0] op);
    sat_opacity = (op > OPAC_FULL) ? OPAC_FULL : op;
  endfunction

endpackage

### rtl/gsb_geom.sv
module gsb_geom import gsb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] pix_x,
  input  logic [COORD_W-1:0] pix_y,
  input  side_t              pix_side,
  input  cfg_t               cfg,
  output logic               geo_valid,
  output logic [RAD_W-1:0]   geo_rad,
  output side_t              geo_side
);

  localparam int OFS_W = COORD_W + 2;
  localparam int DX_W  = 1 + COORD_W + FRAC_W;
  localparam int W_W   = SIZE_W + ASPECT_W;
  localparam int XB_W  = 2 + CENTER_W + 8;   // center_x * 512 plus headroom
  localparam int YB_W  = 2 + CENTER_W;       // center_y * 2 plus headroom

  // stage 1: box test, offsets, rectangle half width
  logic signed [OFS_W-1:0] ox;
  logic signed [OFS_W-1:0] oy;
  logic signed [OFS_W-1:0] rad_s;
  logic signed [DX_W-1:0]  dx;
  logic signed [DX_W-1:0]  dy;
  logic [DX_W-1:0]         ndx;
  logic [DX_W-1:0]         ndy;

  logic                    v1;
  logic [COORD_W-1:0]      px1;
  logic [COORD_W-1:0]      py1;
  logic [ROOT_W-1:0]       adx1;
  logic [ROOT_W-1:0]       ady1;
  logic                    box1;
  logic                    bnd1;
  logic [W_W-1:0]          w1;
  side_t                   side1;

  always_comb begin
    ox    = $signed({2'b00, pix_x}) - $signed({2'b00, cfg.center_x[CENTER_W-1:FRAC_W]});
    oy    = $signed({2'b00, pix_y}) - $signed({2'b00, cfg.center_y[CENTER_W-1:FRAC_W]});
    rad_s = $signed({6'b0, cfg.grain_size[SIZE_W-1:FRAC_W]});
    dx    = $signed({1'b0, pix_x, {FRAC_W{1'b0}}}) - $signed({1'b0, cfg.center_x});
    dy    = $signed({1'b0, pix_y, {FRAC_W{1'b0}}}) - $signed({1'b0, cfg.center_y});
    ndx   = -dx;
    ndy   = -dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    px1   <= pix_x;
    py1   <= pix_y;
    adx1  <= dx[DX_W-1] ? ndx[ROOT_W-1:0] : dx[ROOT_W-1:0];
    ady1  <= dy[DX_W-1] ? ndy[ROOT_W-1:0] : dy[ROOT_W-1:0];
    box1  <= (ox >= -rad_s) && (ox <= rad_s) && (oy >= -rad_s) && (oy <= rad_s);
    bnd1  <= (DIM_W'(pix_x) < DIM_W'(MAX_WIDTH)) && (DIM_W'(pix_y) < DIM_W'(MAX_HEIGHT));
    w1    <= cfg.grain_size * cfg.aspect;
    side1 <= pix_side;
  end

  // stage 2: squares, radius squared, rectangle bounds
  logic [XB_W-1:0] x_lo;
  logic [XB_W-1:0] x_hi;
  logic [YB_W-1:0] y_lo;
  logic [YB_W-1:0] y_hi;
  logic            tab_in;

  logic            v2;
  logic [RAD_W-1:0] sqx2;
  logic [RAD_W-1:0] sqy2;
  logic [RAD_W-1:0] ss2;
  logic            box2;
  logic            bnd2;
  logic            tab2;
  side_t           side2;

  always_comb begin
    x_lo = {1'b0, cfg.center_x, 9'b0} - {2'b0, w1};
    x_hi = {1'b0, cfg.center_x, 9'b0} + {2'b0, w1};
    y_lo = {1'b0, cfg.center_y, 1'b0} - {6'b0, cfg.grain_size};
    y_hi = {1'b0, cfg.center_y, 1'b0} + {6'b0, cfg.grain_size};
    // negative start bounds truncate toward zero, so any pixel passes them
    tab_in = (x_lo[XB_W-1] || (px1 >= x_lo[XB_W-2:17]))
          && ({1'b0, px1} <= x_hi[XB_W-1:17])
          && (y_lo[YB_W-1] || (py1 >= y_lo[YB_W-2:9]))
          && ({1'b0, py1} <= y_hi[YB_W-1:9]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sqx2  <= adx1 * adx1;
    sqy2  <= ady1 * ady1;
    ss2   <= cfg.grain_size * cfg.grain_size;
    box2  <= box1;
    bnd2  <= bnd1;
    tab2  <= tab_in;
    side2 <= side1;
  end

  // stage 3: distance compare and coverage
  logic [RAD_W:0] d2;
  logic           in_circle;
  side_t          cov_side;
  logic           v3;
  logic [RAD_W-1:0] rad3;
  side_t          side3;

  always_comb begin
    d2           = {1'b0, sqx2} + {1'b0, sqy2};
    in_circle    = box2 && (d2 <= {1'b0, ss2});
    cov_side     = side2;
    cov_side.hit = bnd2 && ((cfg.shape_mode == SHAPE_RECT) ? tab2 : in_circle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    rad3  <= d2[RAD_W-1:0];
    side3 <= cov_side;
  end

  assign geo_valid = v3;
  assign geo_rad   = rad3;
  assign geo_side  = side3;

endmodule

### rtl/gsb_sqrt.sv
module gsb_sqrt import gsb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  // one result bit per stage, most significant first
  logic             vld  [ROOT_W];
  logic [RAD_W-1:0] rem  [ROOT_W];
  logic [RAD_W-1:0] root [ROOT_W];
  side_t            side [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = {{(RAD_W-1){1'b0}}, 1'b1} << (RAD_W - 2 - 2 * k);

    logic             src_vld;
    logic [RAD_W-1:0] src_rem;
    logic [RAD_W-1:0] src_root;
    side_t            src_side;
    logic [RAD_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = in_rad;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld[k-1];
      assign src_rem  = rem[k-1];
      assign src_root = root[k-1];
      assign src_side = side[k-1];
    end

    always_comb begin
      trial = src_root + BIT;
      take  = src_rem >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= src_vld;
      end
      rem[k]  <= take ? (src_rem - trial) : src_rem;
      root[k] <= take ? ((src_root >> 1) + BIT) : (src_root >> 1);
      side[k] <= src_side;
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1][ROOT_W-1:0];
  assign out_side  = side[ROOT_W-1];

endmodule

### rtl/gsb_weight.sv
module gsb_weight import gsb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_dist,
  input  side_t             in_side,
  input  cfg_t              cfg,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output side_t             out_side
);

  // dividend: opacity * (size - dist) * 256
  logic [PROD_W-1:0] prod;
  logic              nv;
  logic [NUM_W-1:0]  num;
  side_t             nside;

  assign prod = sat_opacity(cfg.opacity) * (cfg.grain_size - in_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
    end else begin
      nv <= in_valid;
    end
    num   <= {prod[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    nside <= in_side;
  end

  // restoring division by grain_size, one quotient bit per stage;
  // the quotient stays below 2^17, so the top dividend bits start as remainder
  logic              vld [QUO_W];
  logic [SIZE_W-1:0] rem [QUO_W];
  logic [QUO_W-1:0]  lo  [QUO_W];
  logic [QUO_W-1:0]  quo [QUO_W];
  side_t             side [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              src_vld;
    logic [SIZE_W-1:0] src_rem;
    logic [QUO_W-1:0]  src_lo;
    logic [QUO_W-1:0]  src_quo;
    side_t             src_side;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_vld  = nv;
      assign src_rem  = {1'b0, num[NUM_W-1:QUO_W]};
      assign src_lo   = num[QUO_W-1:0];
      assign src_quo  = '0;
      assign src_side = nside;
    end else begin : g_next
      assign src_vld  = vld[k-1];
      assign src_rem  = rem[k-1];
      assign src_lo   = lo[k-1];
      assign src_quo  = quo[k-1];
      assign src_side = side[k-1];
    end

    always_comb begin
      trial = {src_rem, src_lo[QUO_W-1]};
      diff  = trial - {1'b0, cfg.grain_size};
      ge    = trial >= {1'b0, cfg.grain_size};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= src_vld;
      end
      rem[k]  <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      lo[k]   <= src_lo << 1;
      quo[k]  <= {src_quo[QUO_W-2:0], ge};
      side[k] <= src_side;
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_quo   = quo[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

### rtl/gsb_blend.sv
module gsb_blend import gsb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [QUO_W-1:0]  in_quo,
  input  side_t             in_side,
  input  cfg_t              cfg,
  output logic              done,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic              covered
);

  localparam int DIF_W = CHAN_W + 1;
  localparam int MUL_W = DIF_W + WGT_W + 1;
  localparam int SUM_W = CHAN_W + 3;

  logic [OPAC_W-1:0]  op;
  logic [WGT_W-1:0]   wgt;
  logic [WGT_W+7:0]   op255;
  logic [CHAN_W-1:0]  gray;
  logic [CHAN_W-1:0]  tgt [3];
  logic [CHAN_W-1:0]  src [3];
  logic               en  [3];
  logic signed [DIF_W-1:0] dif [3];
  logic signed [MUL_W-1:0] mul [3];

  // stage 1 registers
  logic                    v1;
  logic                    ins1;
  logic [CHAN_W-1:0]       src1 [3];
  logic signed [MUL_W-1:0] mul1 [3];

  always_comb begin
    op    = sat_opacity(in_side.hit ? cfg.opacity : '0);
    op255 = {op, 8'b0} - (WGT_W+8)'(op);
    gray  = op255[15:8];
    priority if (!in_side.hit) begin
      wgt = '0;
    end else if (cfg.shape_mode == SHAPE_RECT || cfg.grain_size == '0) begin
      wgt = {op, 8'b0};
    end else begin
      wgt = in_quo;
    end
    src[0] = in_side.red;
    src[1] = in_side.green;
    src[2] = in_side.blue;
    if (cfg.shape_mode == SHAPE_RECT) begin
      tgt[0] = gray;
      tgt[1] = gray;
      tgt[2] = gray;
    end else begin
      tgt[0] = cfg.grain_color[23:16];
      tgt[1] = cfg.grain_color[15:8];
      tgt[2] = cfg.grain_color[7:0];
    end
    en[0] = in_side.hit && (cfg.channels_used >= 2'd1);
    en[1] = in_side.hit && (cfg.channels_used >= 2'd2);
    en[2] = in_side.hit && (cfg.channels_used == 2'd3);
    for (int c = 0; c < 3; c++) begin
      // out = in + floor((target - in) * w / 65536)
      dif[c] = $signed({1'b0, tgt[c]}) - $signed({1'b0, src[c]});
      if (en[c]) begin
        mul[c] = dif[c] * $signed({1'b0, wgt});
      end else begin
        mul[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ins1 <= in_side.hit;
    for (int c = 0; c < 3; c++) begin
      src1[c] <= src[c];
      mul1[c] <= mul[c];
    end
  end

  // stage 2: add the shifted difference, output register
  logic signed [SUM_W-1:0] sum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = $signed({3'b000, src1[c]}) + $signed(mul1[c][MUL_W-1:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    covered   <= ins1;
    out_red   <= sum[0][CHAN_W-1:0];
    out_green <= sum[1][CHAN_W-1:0];
    out_blue  <= sum[2][CHAN_W-1:0];
  end

  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> (wgt <= {1'b1, 16'b0}))
    else $error("blend weight above one");

  a_uncovered_pass: assert property (@(posedge clk) disable iff (rst)
    (done && !covered) |->
      (out_red == $past(src1[0]) && out_green == $past(src1[1])
       && out_blue == $past(src1[2])))
    else $error("uncovered pixel changed");

  a_unused_channel: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cfg.channels_used) != 2'd3) |-> (out_blue == $past(src1[2])))
    else $error("unused blue channel changed");

endmodule

### rtl/grain_splat_pixel_blend.sv
// grain particle splat into a pixel stream
//
// configuration: apb-style slave, 8 registers at byte address 4*index
// (shape_mode, center_x, center_y, grain_size, opacity, grain_color,
// aspect, channels_used); writes complete in the access phase, pready is
// tied high, reads return the register value. write only while no pixel
// is in flight.
// request channel: a pixel with its coordinates is taken on every clock
// where start is high; busy is tied low, so one pixel per cycle is taken
// with no gaps.
// result channel: done is high for exactly one cycle with out_red,
// out_green, out_blue and covered; there is no back pressure.
// pipeline: geometry stages, then the 16-stage square root, the dividend
// register, the 17-stage divider and the blend stages.
// throughput: one pixel per clock, results leave in request order.
// reset: synchronous, clears all pipeline valid bits and loads the
// register defaults; results already in flight are dropped.
module grain_splat_pixel_blend import gsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // request
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_W-1:0]    pix_x,
  input  logic [COORD_W-1:0]    pix_y,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_blue,
  // result
  output logic                  done,
  output logic [CHAN_W-1:0]     out_red,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_blue,
  output logic                  covered,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------
  cfg_t     cfg;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape_mode    <= SHAPE_CIRCLE;
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.grain_size    <= RST_GRAIN_SIZE;
      cfg.opacity       <= RST_OPACITY;
      cfg.grain_color   <= RST_GRAIN_COLOR;
      cfg.aspect        <= RST_ASPECT;
      cfg.channels_used <= RST_CHANNELS_USED;
    end else if (wr_en) begin
      unique case (idx)
        REG_SHAPE_MODE:    cfg.shape_mode    <= pwdata[0];
        REG_CENTER_X:      cfg.center_x      <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:      cfg.center_y      <= pwdata[CENTER_W-1:0];
        REG_GRAIN_SIZE:    cfg.grain_size    <= pwdata[SIZE_W-1:0];
        REG_OPACITY:       cfg.opacity       <= pwdata[OPAC_W-1:0];
        REG_GRAIN_COLOR:   cfg.grain_color   <= pwdata[COLOR_W-1:0];
        REG_ASPECT:        cfg.aspect        <= pwdata[ASPECT_W-1:0];
        REG_CHANNELS_USED: cfg.channels_used <= pwdata[CHUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux, zero extended
  always_comb begin
    unique case (idx)
      REG_SHAPE_MODE:    prdata = CFG_DATA_W'(cfg.shape_mode);
      REG_CENTER_X:      prdata = CFG_DATA_W'(cfg.center_x);
      REG_CENTER_Y:      prdata = CFG_DATA_W'(cfg.center_y);
      REG_GRAIN_SIZE:    prdata = CFG_DATA_W'(cfg.grain_size);
      REG_OPACITY:       prdata = CFG_DATA_W'(cfg.opacity);
      REG_GRAIN_COLOR:   prdata = CFG_DATA_W'(cfg.grain_color);
      REG_ASPECT:        prdata = CFG_DATA_W'(cfg.aspect);
      REG_CHANNELS_USED: prdata = CFG_DATA_W'(cfg.channels_used);
      default:           prdata = '0;
    endcase
  end

  // the pipeline never stalls, so every request is taken
  assign busy = 1'b0;

  // ---------------------------------------------------------------
  // datapath: geometry -> square root -> falloff divide -> blend
  // ---------------------------------------------------------------
  side_t              pix_side;
  logic               geo_valid;
  logic [RAD_W-1:0]   geo_rad;
  side_t              geo_side;
  logic               rt_valid;
  logic [ROOT_W-1:0]  rt_root;
  side_t              rt_side;
  logic               wt_valid;
  logic [QUO_W-1:0]   wt_quo;
  side_t              wt_side;

  always_comb begin
    pix_side.hit    = 1'b0;
    pix_side.red    = in_red;
    pix_side.green  = in_green;
    pix_side.blue   = in_blue;
  end

  // coverage test and squared distance, 3 stages
  gsb_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .start     (start && !busy),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_side  (pix_side),
    .cfg       (cfg),
    .geo_valid (geo_valid),
    .geo_rad   (geo_rad),
    .geo_side  (geo_side)
  );

  // floor square root of the squared distance, one bit per stage
  gsb_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (geo_valid),
    .in_rad    (geo_rad),
    .in_side   (geo_side),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // linear falloff weight: opacity * (size - dist) * 256 / size
  gsb_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_valid),
    .in_dist   (rt_root),
    .in_side   (rt_side),
    .cfg       (cfg),
    .out_valid (wt_valid),
    .out_quo   (wt_quo),
    .out_side  (wt_side)
  );

  // per-channel blend and output register
  gsb_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wt_valid),
    .in_quo    (wt_quo),
    .in_side   (wt_side),
    .cfg       (cfg),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .covered   (covered)
  );

endmodule
